### src/sopq_pkg.sv
// Shared types, request and status codes for the sequence-ordered packet queue.
package sopq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int TAG_BITS_DEF = 16;

    localparam int SEQ_W    = 32;
    localparam int TAG_W    = 16;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 120;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_COMMIT = 2'b10
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
    } t_stat;

endpackage

### src/sopq_ctrl.sv
// Controller state machine: request capture, commit and result handshake.
module sopq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output sopq_pkg::t_cmd   o_cmd,
    input  sopq_pkg::t_stat  i_stat
);

    sopq_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    assign o_in_ready  = (r_state == sopq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid && !i_out_ready;
        o_cmd.capture  = 1'b0;
        o_cmd.commit   = 1'b0;
        unique case (r_state)
            sopq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = sopq_pkg::S_COMMIT;
                end
            end
            sopq_pkg::S_COMMIT: begin
                // hold until the result register can take the new item
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = sopq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sopq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sopq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_commit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("commit would overwrite a pending result");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("committed item not presented");

    a_capture_then_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == sopq_pkg::S_COMMIT))
        else $error("captured item not followed by commit state");

    a_full_empty_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_stat.full && i_stat.empty))
        else $error("queue reported full and empty at once");

endmodule

### src/sopq_dpath.sv
// Datapath: row of queue cells, compare vector, suffix-OR network and result register.
module sopq_dpath #(
    parameter int DEPTH    = sopq_pkg::DEPTH_DEF,
    parameter int TAG_BITS = sopq_pkg::TAG_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sopq_pkg::t_cmd                     i_cmd,
    output sopq_pkg::t_stat                    o_stat,
    input  logic [sopq_pkg::REQ_W-1:0]         i_req,
    input  logic [sopq_pkg::SEQ_W-1:0]         i_seq,
    input  logic [sopq_pkg::TAG_W-1:0]         i_tag,
    output logic [sopq_pkg::STATUS_W-1:0]      o_res_user,
    output logic [sopq_pkg::OUT_DATA_W-1:0]    o_res_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = (TAG_BITS < sopq_pkg::TAG_W) ? TAG_BITS : sopq_pkg::TAG_W;
    localparam int LV = $clog2(DEPTH);

    logic [sopq_pkg::SEQ_W-1:0] r_slot_seq [DEPTH];
    logic [TW-1:0]              r_slot_tag [DEPTH];
    logic [sopq_pkg::SEQ_W-1:0] n_slot_seq [DEPTH];
    logic [TW-1:0]              n_slot_tag [DEPTH];
    logic [CW-1:0]              r_count, n_count;
    logic [sopq_pkg::SEQ_W-1:0] r_tail, n_tail;

    logic [sopq_pkg::REQ_W-1:0] r_req;
    logic [sopq_pkg::SEQ_W-1:0] r_seq;
    logic [TW-1:0]              r_tag;
    logic [DEPTH-1:0]           r_le;

    logic [sopq_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [sopq_pkg::SEQ_W-1:0]    r_out_rseq, n_out_rseq;
    logic [TW-1:0]                 r_out_rtag, n_out_rtag;
    logic [CW-1:0]                 r_out_count;
    logic [sopq_pkg::SEQ_W-1:0]    r_out_head, n_out_head;
    logic [sopq_pkg::SEQ_W-1:0]    r_out_tail, n_out_tail;

    logic [DEPTH-1:0] w_pre [LV+1];
    logic [DEPTH-1:0] w_suf;
    logic             w_full, w_empty;
    logic             w_do_ins, w_do_app, w_do_rem;
    logic             w_tail_hit;
    logic [sopq_pkg::COUNT_W-1:0] w_cnt5;
    logic [sopq_pkg::TAG_W-1:0]   w_rtag16;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);
    assign o_stat.full  = w_full;
    assign o_stat.empty = w_empty;

    assign w_do_ins = i_cmd.commit && (r_req == sopq_pkg::REQ_INSERT) && !w_full;
    assign w_do_app = i_cmd.commit && (r_req == sopq_pkg::REQ_APPEND) && !w_full;
    assign w_do_rem = i_cmd.commit && (r_req == sopq_pkg::REQ_REMOVE) && !w_empty;

    // suffix OR of the compare vector: w_suf[j] set when some held entry at or
    // beyond j is not larger than the new sequence
    always_comb begin
        w_pre[0] = r_le;
        for (int l = 0; l < LV; l++) begin
            for (int j = 0; j < DEPTH; j++) begin
                if (j + (1 << l) < DEPTH) begin
                    w_pre[l+1][j] = w_pre[l][j] | w_pre[l][j + (1 << l)];
                end else begin
                    w_pre[l+1][j] = w_pre[l][j];
                end
            end
        end
        w_suf = w_pre[LV];
    end

    // per-cell next value: shift toward the head, shift toward the tail, load, hold
    always_comb begin
        w_tail_hit = 1'b0;
        for (int j = 0; j < DEPTH; j++) begin
            n_slot_seq[j] = r_slot_seq[j];
            n_slot_tag[j] = r_slot_tag[j];
            if (w_do_rem) begin
                if (j < DEPTH - 1) begin
                    n_slot_seq[j] = r_slot_seq[j+1];
                    n_slot_tag[j] = r_slot_tag[j+1];
                end
            end else if (w_do_app) begin
                if (CW'(j) == r_count) begin
                    n_slot_seq[j] = r_seq;
                    n_slot_tag[j] = r_tag;
                end
            end else if (w_do_ins) begin
                if (j == 0) begin
                    if (!w_suf[0]) begin
                        n_slot_seq[j] = r_seq;
                        n_slot_tag[j] = r_tag;
                        w_tail_hit    = w_tail_hit | (r_count == '0);
                    end
                end else if (!w_suf[j-1]) begin
                    n_slot_seq[j] = r_slot_seq[j-1];
                    n_slot_tag[j] = r_slot_tag[j-1];
                end else if (!w_suf[j]) begin
                    n_slot_seq[j] = r_seq;
                    n_slot_tag[j] = r_tag;
                    w_tail_hit    = w_tail_hit | (CW'(j) == r_count);
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_tail  = r_tail;
        if (w_do_ins || w_do_app) begin
            n_count = r_count + CW'(1);
        end else if (w_do_rem) begin
            n_count = r_count - CW'(1);
        end
        if (w_do_app || (w_do_ins && w_tail_hit)) begin
            n_tail = r_seq;
        end

        n_out_status = sopq_pkg::ST_DONE;
        if ((r_req == sopq_pkg::REQ_INSERT || r_req == sopq_pkg::REQ_APPEND) && w_full) begin
            n_out_status = sopq_pkg::ST_FULL;
        end else if (r_req == sopq_pkg::REQ_REMOVE && w_empty) begin
            n_out_status = sopq_pkg::ST_EMPTY;
        end
        n_out_rseq = w_do_rem ? r_slot_seq[0] : '0;
        n_out_rtag = w_do_rem ? r_slot_tag[0] : '0;
        n_out_head = (n_count == '0) ? '0 : n_slot_seq[0];
        n_out_tail = (n_count == '0) ? '0 : n_tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
            r_seq <= i_seq;
            r_tag <= i_tag[TW-1:0];
            for (int j = 0; j < DEPTH; j++) begin
                r_le[j] <= (CW'(j) < r_count) && (r_slot_seq[j] <= i_seq);
            end
        end
        if (i_cmd.commit) begin
            for (int j = 0; j < DEPTH; j++) begin
                r_slot_seq[j] <= n_slot_seq[j];
                r_slot_tag[j] <= n_slot_tag[j];
            end
            r_tail       <= n_tail;
            r_out_status <= n_out_status;
            r_out_rseq   <= n_out_rseq;
            r_out_rtag   <= n_out_rtag;
            r_out_count  <= n_count;
            r_out_head   <= n_out_head;
            r_out_tail   <= n_out_tail;
        end
    end

    generate
        if (CW >= sopq_pkg::COUNT_W) begin : g_cnt_trunc
            assign w_cnt5 = r_out_count[sopq_pkg::COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign w_cnt5 = {{(sopq_pkg::COUNT_W - CW){1'b0}}, r_out_count};
        end
        if (TW == sopq_pkg::TAG_W) begin : g_tag_full
            assign w_rtag16 = r_out_rtag;
        end else begin : g_tag_ext
            assign w_rtag16 = {{(sopq_pkg::TAG_W - TW){1'b0}}, r_out_rtag};
        end
    endgenerate

    assign o_res_user = r_out_status;
    assign o_res_data = {2'b00, r_out_tail, r_out_head, (r_out_count == '0), w_cnt5,
                         w_rtag16, r_out_rseq};

endmodule

### src/sequence_ordered_packet_queue.sv
// Top level of the sequence-ordered packet descriptor queue.
// An accepted item is captured with its compare vector and committed to the result register
// once that register is free; a stalled result holds the commit step until it is taken.
// A new item is accepted only after the previous one is committed, set by the capture/commit
// sequence of the controller (compare against all cells, then a shift of the whole cell row).
// Reset: synchronous, active low; clears the entry count, the controller state and
// the result valid flag. Queue cells hold no reset value and are only read below the count.
module sequence_ordered_packet_queue #(
    parameter int DEPTH    = sopq_pkg::DEPTH_DEF,
    parameter int TAG_BITS = sopq_pkg::TAG_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // seq [31:0], entry_tag [47:32]
    input  logic [sopq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type [1:0]
    input  logic [sopq_pkg::REQ_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // removed_seq [31:0], removed_tag [47:32], entry_count [52:48], queue_empty [53],
    // head_seq [85:54], tail_seq [117:86], zero pad [119:118]
    output logic [sopq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // status [1:0]
    output logic [sopq_pkg::STATUS_W-1:0]     m_axis_tuser
);

    // Command and status between the controller and the cell datapath.
    sopq_pkg::t_cmd  w_cmd;
    sopq_pkg::t_stat w_stat;

    // Controller: accept an item, then commit it once the result register is free.
    sopq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // Datapath: capture compares every held cell against the new sequence; commit updates the
    // cell row (shift for insert or remove, load at the count for append) and loads the result.
    sopq_dpath #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_req      (s_axis_tuser),
        .i_seq      (s_axis_tdata[sopq_pkg::SEQ_W-1:0]),
        .i_tag      (s_axis_tdata[sopq_pkg::SEQ_W +: sopq_pkg::TAG_W]),
        .o_res_user (m_axis_tuser),
        .o_res_data (m_axis_tdata)
    );

endmodule

### tb/tb_sequence_ordered_packet_queue.sv
// Self-checking stream testbench for the sequence-ordered packet descriptor queue.
module tb_sequence_ordered_packet_queue;

    localparam int DEPTH    = sopq_pkg::DEPTH_DEF;
    localparam int TAG_BITS = sopq_pkg::TAG_BITS_DEF;

    // Request code 3 has no function; the block treats it as a no-op.
    localparam logic [sopq_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int N_RANDOM    = 1425;
    localparam int HOLD_CYCLES = 500;   // long receiver hold-off, in cycles
    localparam int STALL_LIMIT = 4000;  // cycles with no item moving on either side
    localparam int MAX_REPORTS = 10;

    // One result item, unpacked from tuser/tdata.
    typedef struct packed {
        logic [sopq_pkg::STATUS_W-1:0] status;
        logic [sopq_pkg::SEQ_W-1:0]    removed_seq;
        logic [sopq_pkg::TAG_W-1:0]    removed_tag;
        logic [sopq_pkg::COUNT_W-1:0]  entry_count;
        logic                          queue_empty;
        logic [sopq_pkg::SEQ_W-1:0]    head_seq;
        logic [sopq_pkg::SEQ_W-1:0]    tail_seq;
    } t_qresult;

    // One row of the directed part. Where typed is set, want is the result read off by hand.
    typedef struct {
        logic [sopq_pkg::REQ_W-1:0] req;
        logic [sopq_pkg::SEQ_W-1:0] seq;
        logic [sopq_pkg::TAG_W-1:0] tag;
        bit                         typed;
        t_qresult                   want;
    } t_stim_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [sopq_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // seq [31:0], entry_tag [47:32]
    logic [sopq_pkg::REQ_W-1:0]      s_axis_tuser;   // req_type [1:0]
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // removed_seq [31:0], removed_tag [47:32], entry_count [52:48], queue_empty [53],
    // head_seq [85:54], tail_seq [117:86], zero pad [119:118]
    logic [sopq_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [sopq_pkg::STATUS_W-1:0]   m_axis_tuser;   // status [1:0]

    sequence_ordered_packet_queue #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow copy of the queue contents; slot 0 is the head.
    logic [sopq_pkg::SEQ_W-1:0] shadow_seq [DEPTH];
    logic [sopq_pkg::TAG_W-1:0] shadow_tag [DEPTH];
    int                         shadow_count;

    t_qresult  pending_results [$];
    t_stim_row dir_rows [$];

    int  mismatches;
    int  n_items;
    int  n_results;
    int  n_full_drops;
    int  n_empty_removes;
    int  n_noops;
    int  peak_count;
    int  idle_cycles;
    bit  hold_rx;

    // ------------------------------------------------------------------
    // Clock: period 20.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: apply one request to the shadow queue and return the
    // result item it must produce.
    // ------------------------------------------------------------------
    function automatic t_qresult predict_request(input logic [sopq_pkg::REQ_W-1:0] req,
                                                 input logic [sopq_pkg::SEQ_W-1:0] s,
                                                 input logic [sopq_pkg::TAG_W-1:0] t);
        t_qresult                   r;
        int                         pos;
        logic [sopq_pkg::TAG_W-1:0] tm;
        r  = '0;
        tm = t & sopq_pkg::TAG_W'((64'd1 << TAG_BITS) - 1);
        if (req == sopq_pkg::REQ_INSERT || req == sopq_pkg::REQ_APPEND) begin
            if (shadow_count >= DEPTH) begin
                r.status = sopq_pkg::ST_FULL;
                n_full_drops++;
            end else begin
                if (req == sopq_pkg::REQ_APPEND) begin
                    pos = shadow_count;
                end else begin
                    // Scan from the tail: go right after the last entry not larger than s.
                    pos = 0;
                    for (int i = shadow_count; i > 0; i--) begin
                        if (shadow_seq[i-1] <= s) begin
                            pos = i;
                            break;
                        end
                    end
                end
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_seq[i] = shadow_seq[i-1];
                    shadow_tag[i] = shadow_tag[i-1];
                end
                shadow_seq[pos] = s;
                shadow_tag[pos] = tm;
                shadow_count++;
                r.status = sopq_pkg::ST_DONE;
            end
        end else if (req == sopq_pkg::REQ_REMOVE) begin
            if (shadow_count == 0) begin
                r.status = sopq_pkg::ST_EMPTY;
                n_empty_removes++;
            end else begin
                r.status      = sopq_pkg::ST_DONE;
                r.removed_seq = shadow_seq[0];
                r.removed_tag = shadow_tag[0];
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_seq[i-1] = shadow_seq[i];
                    shadow_tag[i-1] = shadow_tag[i];
                end
                shadow_count--;
            end
        end else begin
            r.status = sopq_pkg::ST_DONE;
            n_noops++;
        end
        if (shadow_count > peak_count) peak_count = shadow_count;
        r.entry_count = sopq_pkg::COUNT_W'(shadow_count);
        r.queue_empty = (shadow_count == 0);
        r.head_seq    = (shadow_count == 0) ? '0 : shadow_seq[0];
        r.tail_seq    = (shadow_count == 0) ? '0 : shadow_seq[shadow_count-1];
        return r;
    endfunction

    // Wait time before the next item on either side; zero inside a burst.
    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic add_row(input logic [sopq_pkg::REQ_W-1:0] r,
                           input logic [sopq_pkg::SEQ_W-1:0] s,
                           input logic [sopq_pkg::TAG_W-1:0] t, input bit typed = 1'b0,
                           input t_qresult want = '0);
        t_stim_row row;
        row.req   = r;
        row.seq   = s;
        row.tag   = t;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Offer one request item after gap idle cycles; hold it until accepted.
    // Call and return at a falling edge.
    task automatic send_request(input t_stim_row row, input int gap);
        t_qresult predicted;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row.tag, row.seq};
        s_axis_tuser  <= row.req;
        do @(posedge i_clk); while (!s_axis_tready);
        // Accepted at this edge: advance the shadow queue and queue the result.
        predicted = predict_request(row.req, row.seq, row.tag);
        pending_results.push_back(row.typed ? row.want : predicted);
        n_items++;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sender: reset, directed rows, then random traffic.
    // ------------------------------------------------------------------
    initial begin
        t_stim_row row;
        bit        burst;
        int        bias;
        int        pick;
        int        sel;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = sopq_pkg::REQ_INSERT;
        hold_rx       = 1'b0;
        shadow_count  = 0;
        mismatches    = 0;
        n_items       = 0;
        n_full_drops  = 0;
        n_empty_removes = 0;
        n_noops       = 0;
        peak_count    = 0;
        burst         = 1'b0;
        bias          = 2;

        // Directed part. Empty queue first: remove and the unused code.
        add_row(sopq_pkg::REQ_REMOVE, 32'h0, 16'h0, 1'b1,
                '{sopq_pkg::ST_EMPTY, 32'd0, 16'd0, 5'd0, 1'b1, 32'd0, 32'd0});
        add_row(REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                '{sopq_pkg::ST_DONE, 32'd0, 16'd0, 5'd0, 1'b1, 32'd0, 32'd0});
        // Ordered inserts at both sequence extremes.
        add_row(sopq_pkg::REQ_INSERT, 32'd100, 16'h1234, 1'b1,
                '{sopq_pkg::ST_DONE, 32'd0, 16'd0, 5'd1, 1'b0, 32'd100, 32'd100});
        add_row(sopq_pkg::REQ_INSERT, 32'd0, 16'h0000, 1'b1,
                '{sopq_pkg::ST_DONE, 32'd0, 16'd0, 5'd2, 1'b0, 32'd0, 32'd100});
        add_row(sopq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                '{sopq_pkg::ST_DONE, 32'd0, 16'd0, 5'd3, 1'b0, 32'd0, 32'hFFFF_FFFF});
        // Equal sequence goes after the existing one.
        add_row(sopq_pkg::REQ_INSERT, 32'd100, 16'hAAAA);
        // Append out of order, then ordered inserts into the unsorted queue.
        add_row(sopq_pkg::REQ_APPEND, 32'd5, 16'h5555);
        add_row(sopq_pkg::REQ_INSERT, 32'd7, 16'h0707);
        add_row(sopq_pkg::REQ_INSERT, 32'd3, 16'h0303);
        add_row(REQ_UNUSED, 32'h1234_5678, 16'h9ABC);
        add_row(sopq_pkg::REQ_REMOVE, 32'hDEAD_BEEF, 16'hBEEF);
        // Fill the queue to DEPTH by appends; the last one sets the tail.
        for (int k = 0; k < 9; k++) begin
            add_row(sopq_pkg::REQ_APPEND, 32'h0000_1000 + k, 16'(16'h8001 << k));
        end
        add_row(sopq_pkg::REQ_APPEND, 32'h8000_0000, 16'h7FFE);
        // Inserts on a full queue are dropped.
        add_row(sopq_pkg::REQ_INSERT, 32'd1, 16'h0001, 1'b1,
                '{sopq_pkg::ST_FULL, 32'd0, 16'd0, 5'd16, 1'b0, 32'd3, 32'h8000_0000});
        add_row(sopq_pkg::REQ_APPEND, 32'd2, 16'h0002, 1'b1,
                '{sopq_pkg::ST_FULL, 32'd0, 16'd0, 5'd16, 1'b0, 32'd3, 32'h8000_0000});
        add_row(sopq_pkg::REQ_REMOVE, 32'd0, 16'd0);
        add_row(sopq_pkg::REQ_REMOVE, 32'd0, 16'd0);

        // Hold reset low, then release it at a falling edge.
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            send_request(dir_rows[k], draw_gap(1'b0));
        end

        // Random part: biased phases drive the queue between full and empty.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 64 == 0) begin
                burst = ($urandom_range(0, 3) == 0);
                bias  = $urandom_range(0, 2);
            end
            // Stall the receiver for a long stretch while offering back to back.
            if (n == 300) hold_rx = 1'b1;
            if (n >= 300 && n < 340) burst = 1'b1;
            // Pause until every expected result has come back.
            if (n == 800) begin
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(negedge i_clk);
            end

            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                row.req = REQ_UNUSED;
            end else begin
                case (bias)
                    0: begin
                        row.req = (pick < 50) ? sopq_pkg::REQ_INSERT :
                                  (pick < 75) ? sopq_pkg::REQ_APPEND : sopq_pkg::REQ_REMOVE;
                    end
                    1: begin
                        row.req = (pick < 20) ? sopq_pkg::REQ_INSERT :
                                  (pick < 30) ? sopq_pkg::REQ_APPEND : sopq_pkg::REQ_REMOVE;
                    end
                    default: begin
                        row.req = (pick < 40) ? sopq_pkg::REQ_INSERT :
                                  (pick < 55) ? sopq_pkg::REQ_APPEND : sopq_pkg::REQ_REMOVE;
                    end
                endcase
            end

            // Small sequence values make equal keys common; keep the extremes in play.
            sel = $urandom_range(0, 9);
            case (sel)
                0:       row.seq = 32'h0;
                1:       row.seq = 32'hFFFF_FFFF;
                2, 3, 4, 5: row.seq = $urandom_range(0, 31);
                default: row.seq = $urandom;
            endcase
            sel = $urandom_range(0, 15);
            row.tag   = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF : 16'($urandom);
            row.typed = 1'b0;
            row.want  = '0;
            send_request(row, draw_gap(burst));
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every result, then wait on for stray items.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d results; peak fill %0d of %0d.",
                 n_items, n_results, peak_count, DEPTH);
        $display("Dropped inserts on full: %0d, removes on empty: %0d, no-ops: %0d.",
                 n_full_drops, n_empty_removes, n_noops);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall before each result item, plus one long hold.
    // ------------------------------------------------------------------
    initial begin
        bit burst;
        int gap;
        int count;
        m_axis_tready = 1'b0;
        burst = 1'b0;
        count = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (count % 64 == 0) burst = ($urandom_range(0, 3) == 0);
            if (hold_rx) begin
                m_axis_tready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(negedge i_clk);
                hold_rx = 1'b0;
            end
            gap = draw_gap(burst);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            count++;
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest one pending.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_qresult got;
        t_qresult want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status      = m_axis_tuser;
            got.removed_seq = m_axis_tdata[31:0];
            got.removed_tag = m_axis_tdata[47:32];
            got.entry_count = m_axis_tdata[52:48];
            got.queue_empty = m_axis_tdata[53];
            got.head_seq    = m_axis_tdata[85:54];
            got.tail_seq    = m_axis_tdata[117:86];
            n_results++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected result item st=%0d cnt=%0d head=%h tail=%h",
                             got.status, got.entry_count, got.head_seq, got.tail_seq);
            end else begin
                want = pending_results.pop_front();
                if (got.status      !== want.status      ||
                    got.removed_seq !== want.removed_seq ||
                    got.removed_tag !== want.removed_tag ||
                    got.entry_count !== want.entry_count ||
                    got.queue_empty !== want.queue_empty ||
                    got.head_seq    !== want.head_seq    ||
                    got.tail_seq    !== want.tail_seq) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display({"ERROR: result %0d want st=%0d rs=%h rt=%h",
                                  " cnt=%0d e=%0d hd=%h tl=%h"},
                                 n_results, want.status, want.removed_seq, want.removed_tag,
                                 want.entry_count, want.queue_empty, want.head_seq,
                                 want.tail_seq);
                        $display({"       result %0d got  st=%0d rs=%h rt=%h",
                                  " cnt=%0d e=%0d hd=%h tl=%h"},
                                 n_results, got.status, got.removed_seq, got.removed_tag,
                                 got.entry_count, got.queue_empty, got.head_seq,
                                 got.tail_seq);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no item moves on either side for too long.
    // ------------------------------------------------------------------
    initial idle_cycles = 0;
    initial n_results = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("ERROR: no item moved for %0d cycles, %0d results pending",
                     idle_cycles, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

### files.f
src/sopq_pkg.sv
src/sopq_ctrl.sv
src/sopq_dpath.sv
src/sequence_ordered_packet_queue.sv
tb/tb_sequence_ordered_packet_queue.sv
